@@ rtl/core/ecov_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge coverage hit map: shared types and constants
// Request and result payloads, queue entry format and register indexes.
// ----------------------------------------------------------------------------
package ecov_pkg;

  localparam int ADDR_W      = 48;
  localparam int READ_IDX_W  = 16;
  localparam int EDGE_W      = 16;
  localparam int CNT_W       = 8;
  // Key field wide enough for the largest supported map (2^20 entries).
  localparam int KEY_W       = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REGION_HIGH = CFG_IDX_W'(1);

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  // Work class decided by the front end.
  typedef enum logic [1:0] {
    KIND_MISS      = 2'd0,
    KIND_HIT       = 2'd1,
    KIND_READ      = 2'd2,
    KIND_READ_NONE = 2'd3
  } kind_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [ADDR_W-1:0]       branch_addr;
    logic [READ_IDX_W-1:0]   read_index;
  } req_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_index;
    logic [CNT_W-1:0]  hit_count;
    logic              recorded;
  } rsp_t;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
  } qentry_t;

endpackage

@@ rtl/core/ecov_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge coverage hit map: front end
// Holds the region registers and classifies each request for the back end.
// ----------------------------------------------------------------------------
module ecov_front
  import ecov_pkg::*;
#(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  req_t                 request,
  output qentry_t              entry
);

  logic [ADDR_W-1:0] region_low;
  logic [ADDR_W-1:0] region_high;
  logic [ADDR_W-1:0] diff;
  logic              in_region;
  logic              in_map;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_low  <= '0;
      region_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_REGION_LOW:  region_low  <= cfg_data;
        REG_REGION_HIGH: region_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only the low bits of the difference survive the map-size reduction.
  assign diff      = region_low - request.branch_addr;
  assign in_region = (request.branch_addr > region_low) &&
                     (request.branch_addr < region_high);
  assign in_map    = ((KEY_W + 1)'(request.read_index) < (KEY_W + 1)'(MAP_ENTRIES));

  always_comb begin
    entry = '0;
    if (request.opcode == OP_READ) begin
      entry.kind = in_map ? KIND_READ : KIND_READ_NONE;
      entry.key  = KEY_W'(request.read_index);
    end else if (in_region) begin
      entry.kind = KIND_HIT;
      entry.key  = diff[KEY_W-1:0];
    end else begin
      entry.kind = KIND_MISS;
    end
  end

endmodule

@@ rtl/core/ecov_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge coverage hit map: decoupling queue
// Small FIFO of classified entries between front end and back end.
// ----------------------------------------------------------------------------
module ecov_queue
  import ecov_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  qentry_t push_entry,
  input  logic    pop,
  output qentry_t head,
  output logic    empty,
  output logic    full
);

  qentry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ rtl/core/ecov_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge coverage hit map: back end
// Hashes with the previous index and runs the counter read-modify-write.
// ----------------------------------------------------------------------------
module ecov_back
  import ecov_pkg::*;
#(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  qentry_t entry,
  output logic    clearing,
  output logic    done,
  output rsp_t    result
);

  localparam int IDX_W = $clog2(MAP_ENTRIES);

  logic [CNT_W-1:0]  hit_map [MAP_ENTRIES];

  logic [IDX_W-1:0]  prev_index;
  logic [IDX_W-1:0]  idx_s1;
  logic [KEY_W-1:0]  idx_ext;
  logic [EDGE_W-1:0] edge_s1;
  logic              s2_valid;
  kind_t             s2_kind;
  logic [IDX_W-1:0]  s2_idx;
  logic [EDGE_W-1:0] s2_edge;
  logic              fwd_valid;
  logic [IDX_W-1:0]  fwd_idx;
  logic [CNT_W-1:0]  fwd_cnt;
  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  new_cnt;
  logic              wr_en;
  logic [IDX_W-1:0]  clr_ptr;
  rsp_t              result_next;

  // First stage: form the map index and issue the read.
  always_comb begin
    idx_s1 = entry.key[IDX_W-1:0];
    if (entry.kind == KIND_HIT) begin
      idx_s1 = entry.key[IDX_W-1:0] ^ prev_index;
    end
    idx_ext = KEY_W'(idx_s1);
    edge_s1 = (entry.kind == KIND_HIT) ? idx_ext[EDGE_W-1:0] : entry.key[EDGE_W-1:0];
  end

  // Second stage: the write of the item just before lands at the same edge as
  // this item's read, so its value is taken from the forwarding register.
  always_comb begin
    cur_cnt     = (fwd_valid && (fwd_idx == s2_idx)) ? fwd_cnt : rd_data;
    new_cnt     = cur_cnt + 1'b1;
    result_next = '0;
    wr_en       = 1'b0;
    unique case (s2_kind)
      KIND_HIT: begin
        result_next.edge_index = s2_edge;
        result_next.hit_count  = new_cnt;
        result_next.recorded   = 1'b1;
        wr_en                  = s2_valid;
      end
      KIND_READ: begin
        result_next.edge_index = s2_edge;
        result_next.hit_count  = cur_cnt;
      end
      KIND_READ_NONE: begin
        result_next.edge_index = s2_edge;
      end
      KIND_MISS: begin
        result_next = '0;
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      fwd_valid  <= 1'b0;
      prev_index <= '0;
      clearing   <= 1'b1;
      clr_ptr    <= '0;
      done       <= 1'b0;
    end else begin
      s2_valid  <= in_valid;
      fwd_valid <= wr_en;
      done      <= s2_valid;
      if (in_valid && (entry.kind == KIND_HIT)) begin
        prev_index <= idx_s1;
      end
      if (clearing) begin
        clr_ptr <= clr_ptr + 1'b1;
        if (clr_ptr == IDX_W'(MAP_ENTRIES - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_kind <= entry.kind;
    s2_idx  <= idx_s1;
    s2_edge <= edge_s1;
    fwd_idx <= s2_idx;
    fwd_cnt <= new_cnt;
    result  <= result_next;
  end

  always_ff @(posedge clk) begin
    rd_data <= hit_map[idx_s1];
    if (clearing) begin
      hit_map[clr_ptr] <= '0;
    end else if (wr_en) begin
      hit_map[s2_idx] <= new_cnt;
    end
  end

endmodule

@@ rtl/core/edge_coverage_hit_map_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge coverage hit map unit
// Counts taken control-flow edges of a traced code region in a map of 8-bit
// wrapping counters, and lets the map be read back one entry at a time.
// ----------------------------------------------------------------------------
//
// Channel    | Handshake                 | Payload
// -----------+---------------------------+----------------------------------
// request    | start, busy (accept when  | request: opcode, branch_addr,
//            | start high and busy low)  | read_index
// result     | done strobe, one cycle    | result: edge_index, hit_count,
//            | (receiver cannot stall)   | recorded
// config     | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// One request is taken per cycle when busy is low; each request returns
// exactly one result after it is accepted. A request passes through the
// queue; the counter memory is then read, the count is incremented and
// written back, and the result is registered. Back-to-back hits to the same
// entry are forwarded. After reset the counter memory is swept to zero with
// busy held high; configuration writes are taken during the sweep.
// Busy is also raised if the front-to-back queue ever fills.
//
// MAP_ENTRIES must be a power of two from 256 to 1048576.
module edge_coverage_hit_map_unit
  import ecov_pkg::*;
#(
  parameter int MAP_ENTRIES = 65536
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 request,
  output logic                 done,
  output rsp_t                 result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  qentry_t front_entry;
  qentry_t queue_head;
  logic    queue_empty;
  logic    queue_full;
  logic    clearing;
  logic    accept;
  logic    issue;

  // The region registers are plain flops, so a write is always taken.
  assign cfg_ready = 1'b1;

  // A request enters the queue on acceptance; the back end drains one entry
  // every cycle once the clearing sweep is finished.
  assign busy   = queue_full || clearing;
  assign accept = start && !busy;
  assign issue  = !queue_empty && !clearing;

  ecov_front #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (request),
    .entry     (front_entry)
  );

  ecov_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (issue),
    .head       (queue_head),
    .empty      (queue_empty),
    .full       (queue_full)
  );

  ecov_back #(
    .MAP_ENTRIES (MAP_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (issue),
    .entry    (queue_head),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

@@ rtl/core/ecov_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge coverage hit map: port checker
// Watches the top-level ports for latency, reset and result consistency.
// ----------------------------------------------------------------------------
module ecov_checker
  import ecov_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t request,
  input logic done,
  input rsp_t result
);

  // The counter sweep after reset keeps requests out.
  a_busy_after_reset: assert property (@(posedge clk) $fell(rst) |-> busy)
    else $error("busy low right after reset");

  // Every accepted request yields its result.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result missing three cycles after a request");

  // A result only follows an accepted request.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a request");

  // A read returns the index asked for and never claims a record.
  a_read_echo: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && !busy && (request.opcode == OP_READ), 3)) |->
      ((result.edge_index == $past(request.read_index, 3)) && !result.recorded))
    else $error("read result does not match the request");

  // A record outside the region reports all zeros.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.recorded && $past(request.opcode == OP_RECORD, 3)) |->
      ((result.edge_index == '0) && (result.hit_count == '0)))
    else $error("uncounted record reports nonzero fields");

endmodule

bind edge_coverage_hit_map_unit ecov_checker u_ecov_checker (.*);
